@@ hw/rtl/tcf_pkg.sv @@
// Shared types and constants for the two-class oldest-first FIFO.
// Used by tcf_cell, tcf_chain and two_class_fifo_oldest_first_core.
// No dependencies.
package tcf_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int STAMP_BITS  = 16;
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [STAMP_BITS-1:0] stamp_type;
   typedef logic [FILL_BITS-1:0]  fill_type;

   // request opcodes
   typedef enum logic [1:0] {
      MODE_PUSH        = 2'd0,
      MODE_POP_FIRST   = 2'd1,
      MODE_POP_SECOND  = 2'd2,
      MODE_POP_OLDEST  = 2'd3
   } mode_type;

   // commands into one class chain
   typedef struct packed {
      logic push;
      logic pop;
   } chain_ctrl_type;

   // occupancy flags out of one class chain
   typedef struct packed {
      logic empty;
      logic full;
      logic single;
   } chain_stat_type;

endpackage

@@ hw/rtl/tcf_cell.sv @@
// One storage cell of a class chain: holds one stamp.
// Loads a pushed stamp or takes its upper neighbor's stamp on a pop.
// Depends on tcf_pkg.
module tcf_cell (
   input  logic               clock,
   input  logic               load,
   input  logic               shift,
   input  tcf_pkg::stamp_type load_stamp,
   input  tcf_pkg::stamp_type neighbor_stamp,
   output tcf_pkg::stamp_type cell_stamp
);

   tcf_pkg::stamp_type stamp_ff;
   tcf_pkg::stamp_type stamp_in;

   // next value: push load wins, pop moves data one cell toward the head
   always_comb begin
      if (load) begin
         stamp_in = load_stamp;
      end else if (shift) begin
         stamp_in = neighbor_stamp;
      end else begin
         stamp_in = stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
   end

   assign cell_stamp = stamp_ff;

endmodule

@@ hw/rtl/tcf_chain.sv @@
// Row of tcf_cell with a fill count: a shifting FIFO for one class.
// Head sits in cell 0; a push writes the cell at the fill position.
// Depends on tcf_pkg and tcf_cell.
module tcf_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  tcf_pkg::chain_ctrl_type ctrl,
   input  tcf_pkg::stamp_type     push_stamp,
   output tcf_pkg::stamp_type     head_stamp,
   output tcf_pkg::chain_stat_type stat
);

   tcf_pkg::fill_type  fill_ff;
   tcf_pkg::fill_type  fill_in;
   tcf_pkg::stamp_type cell_stamps [tcf_pkg::QUEUE_DEPTH];

   // fill count; callers never push when full or pop when empty
   always_comb begin
      fill_in = fill_ff;
      if (ctrl.push) begin
         fill_in = fill_ff + tcf_pkg::FILL_BITS'(1);
      end else if (ctrl.pop) begin
         fill_in = fill_ff - tcf_pkg::FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // the cells; the top cell takes zero on a shift
   for (genvar i = 0; i < tcf_pkg::QUEUE_DEPTH; i++) begin : g_cell
      tcf_pkg::stamp_type neighbor;
      logic               load;

      if (i == tcf_pkg::QUEUE_DEPTH - 1) begin : g_top
         assign neighbor = '0;
      end else begin : g_mid
         assign neighbor = cell_stamps[i+1];
      end

      assign load = ctrl.push && (fill_ff == tcf_pkg::FILL_BITS'(i));

      tcf_cell u_cell (
         .clock          (clock),
         .load           (load),
         .shift          (ctrl.pop),
         .load_stamp     (push_stamp),
         .neighbor_stamp (neighbor),
         .cell_stamp     (cell_stamps[i])
      );
   end

   assign head_stamp  = cell_stamps[0];
   assign stat.empty  = (fill_ff == '0);
   assign stat.full   = (fill_ff == tcf_pkg::FILL_BITS'(tcf_pkg::QUEUE_DEPTH));
   assign stat.single = (fill_ff == tcf_pkg::FILL_BITS'(1));

   // checks
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= tcf_pkg::FILL_BITS'(tcf_pkg::QUEUE_DEPTH))
      else $error("fill count above depth");

   a_one_cmd : assert property (@(posedge clock) disable iff (reset)
      !(ctrl.push && ctrl.pop))
      else $error("push and pop in the same cycle");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> !stat.empty)
      else $error("pop from empty chain");

   a_push_count : assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> fill_ff == $past(fill_ff) + tcf_pkg::FILL_BITS'(1))
      else $error("push did not advance fill count");

endmodule

@@ hw/rtl/two_class_fifo_oldest_first_core.sv @@
// Two-class FIFO with oldest-first pop; top level.
// The result is registered and valid in the cycle after the request transfer.
// One request per cycle while the result is not stalled; a cell chain shifts at most once per cycle, on a pop.
// Reset clears both fill counts and the result valid; stamp cells are not cleared.
// Depends on tcf_pkg, tcf_chain and tcf_cell.
module two_class_fifo_oldest_first_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic                  req_item_class,
   input  tcf_pkg::stamp_type    req_arrival_stamp,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_took_item,
   output logic                  rsp_taken_class,
   output tcf_pkg::stamp_type    rsp_taken_stamp,
   output logic                  rsp_push_dropped,
   output logic                  rsp_first_empty,
   output logic                  rsp_second_empty
);

   tcf_pkg::chain_ctrl_type first_ctrl, second_ctrl;
   tcf_pkg::chain_stat_type first_stat, second_stat;
   tcf_pkg::stamp_type      first_head, second_head;
   tcf_pkg::mode_type       mode;
   logic                    accept;
   logic                    pick_first, pick_second, dropped;
   logic                    first_empty_next, second_empty_next;

   logic                    rsp_valid_ff;
   logic                    took_ff, class_ff, dropped_ff, first_empty_ff, second_empty_ff;
   tcf_pkg::stamp_type      stamp_ff;

   assign mode      = tcf_pkg::mode_type'(req_mode);
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // decode request into chain commands
   always_comb begin
      pick_first  = 1'b0;
      pick_second = 1'b0;
      dropped     = 1'b0;
      first_ctrl  = '0;
      second_ctrl = '0;
      case (mode)
         tcf_pkg::MODE_PUSH: begin
            if (req_item_class) begin
               dropped          = second_stat.full;
               second_ctrl.push = !second_stat.full;
            end else begin
               dropped          = first_stat.full;
               first_ctrl.push  = !first_stat.full;
            end
         end
         tcf_pkg::MODE_POP_FIRST: begin
            pick_first = !first_stat.empty;
         end
         tcf_pkg::MODE_POP_SECOND: begin
            pick_second = !second_stat.empty;
         end
         tcf_pkg::MODE_POP_OLDEST: begin
            // ties go to class 0
            if (!first_stat.empty && !second_stat.empty) begin
               pick_second = (second_head < first_head);
               pick_first  = !(second_head < first_head);
            end else begin
               pick_first  = !first_stat.empty;
               pick_second = !second_stat.empty;
            end
         end
         default: begin
            pick_first = 1'b0;
         end
      endcase
      first_ctrl.pop  = pick_first;
      second_ctrl.pop = pick_second;
      if (!accept) begin
         first_ctrl  = '0;
         second_ctrl = '0;
      end
   end

   // emptiness after this step
   assign first_empty_next  = first_ctrl.pop ? first_stat.single :
                              (first_stat.empty && !first_ctrl.push);
   assign second_empty_next = second_ctrl.pop ? second_stat.single :
                              (second_stat.empty && !second_ctrl.push);

   tcf_chain u_first (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (first_ctrl),
      .push_stamp (req_arrival_stamp),
      .head_stamp (first_head),
      .stat       (first_stat)
   );

   tcf_chain u_second (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (second_ctrl),
      .push_stamp (req_arrival_stamp),
      .head_stamp (second_head),
      .stat       (second_stat)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         took_ff         <= pick_first || pick_second;
         class_ff        <= pick_second;
         stamp_ff        <= pick_first ? first_head :
                            (pick_second ? second_head : '0);
         dropped_ff      <= dropped;
         first_empty_ff  <= first_empty_next;
         second_empty_ff <= second_empty_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_took_item    = took_ff;
   assign rsp_taken_class  = class_ff;
   assign rsp_taken_stamp  = stamp_ff;
   assign rsp_push_dropped = dropped_ff;
   assign rsp_first_empty  = first_empty_ff;
   assign rsp_second_empty = second_empty_ff;

   // checks
   a_single_pick : assert property (@(posedge clock) disable iff (reset)
      !(pick_first && pick_second))
      else $error("both classes picked");

   a_took_no_drop : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(took_ff && dropped_ff))
      else $error("result both delivered and dropped");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !accept)
      else $error("request taken while result stalled");

endmodule
